### rtl/pid_velocity_feedforward_assert.svh
// Assertion macros shared by the speed controller RTL.
// Included by pvff_ctrl and pvff_dp; no other dependencies.
`ifndef PID_VELOCITY_FEEDFORWARD_ASSERT_SVH
`define PID_VELOCITY_FEEDFORWARD_ASSERT_SVH
`ifndef SYNTHESIS
// Check a condition in the same cycle as its trigger
`define PVFF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check a condition in the cycle after its trigger
`define PVFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PVFF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PVFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/pvff_pkg.sv
// Shared constants, widths, command and status types of the speed controller.
// No dependencies; compiled first.
package pvff_pkg;

    // Controller constants
    localparam int MAX_DRIVE      = 255;
    localparam int SLOPE_DENOM    = 100;
    localparam int OUTPUT_DIVISOR = 50;
    localparam int PCT_DENOM      = 100;
    localparam int FF_DIVISOR     = SLOPE_DENOM * PCT_DENOM;

    // Field widths
    localparam int COUNT_W    = 32;
    localparam int TGT_W      = 16;
    localparam int PWM_W      = 9;
    localparam int GAIN_W     = 8;
    localparam int FFC_W      = 10;
    localparam int PCT_W      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    // Datapath widths
    localparam int ERR_W      = COUNT_W + 1;
    localparam int MUL_A_W    = ERR_W + 1;
    localparam int MUL_B_W    = FFC_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W + 1;
    localparam int SUM_W      = PROD_W + 1;
    localparam int ACC_W      = SUM_W;
    localparam int FF_W       = 32;
    localparam int DRIVE_W    = FF_W + 1;
    localparam int SD_W       = $clog2(SLOPE_DENOM + 1);
    localparam int DB_BASE_W  = FFC_W + SD_W;

    // Divider: four quotient bits per cycle
    localparam int DIV_DIGIT  = 4;
    localparam int DIVIDEND_W = 44;
    localparam int DIV_STEPS  = DIVIDEND_W / DIV_DIGIT;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int DIV_MAX    = (FF_DIVISOR > OUTPUT_DIVISOR) ? FF_DIVISOR : OUTPUT_DIVISOR;
    localparam int DIV_W      = $clog2(DIV_MAX + 1);

    // Register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = GAIN_W'(70);
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST   = GAIN_W'(110);
    localparam logic [FFC_W-1:0]  DEADBAND_FWD_RST = FFC_W'(157);
    localparam logic [FFC_W-1:0]  SLOPE_FWD_RST    = FFC_W'(178);
    localparam logic [FFC_W-1:0]  DEADBAND_REV_RST = FFC_W'(142);
    localparam logic [FFC_W-1:0]  SLOPE_REV_RST    = FFC_W'(190);
    localparam logic [PCT_W-1:0]  FF_SCALE_RST     = PCT_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 4'd0,
        CFG_INTEG_GAIN   = 4'd1,
        CFG_DERIV_GAIN   = 4'd2,
        CFG_DEADBAND_FWD = 4'd3,
        CFG_SLOPE_FWD    = 4'd4,
        CFG_DEADBAND_REV = 4'd5,
        CFG_SLOPE_REV    = 4'd6,
        CFG_FF_SCALE_PCT = 4'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MUL_SLOPE_MAG = 3'd0,
        MUL_SUM_PCT   = 3'd1,
        MUL_KP_ERR    = 3'd2,
        MUL_KD_DMEAS  = 3'd3,
        MUL_KI_ERR    = 3'd4
    } t_mul_sel;

    typedef enum logic [2:0] {
        SUM_HOLD      = 3'd0,
        SUM_FF_BASE   = 3'd1,
        SUM_LOAD_PROD = 3'd2,
        SUM_SUB_PROD  = 3'd3,
        SUM_ADD_INTEG = 3'd4
    } t_sum_op;

    typedef enum logic {
        DIV_SRC_FF  = 1'b0,
        DIV_SRC_PID = 1'b1
    } t_div_src;

    typedef struct packed {
        logic     capture;
        logic     resync;
        logic     meas;
        logic     diff;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_sum_op  sum_op;
        logic     div_start;
        t_div_src div_src;
        logic     ff_load;
        logic     acc_load;
        logic     clamp;
        logic     fin;
        logic     integ;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } t_status;

endpackage

### rtl/pvff_if.sv
// Valid/ready channel interfaces: request input, result output, register writes.
// Depends on pvff_pkg for field widths.
interface pvff_in_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [pvff_pkg::COUNT_W-1:0]        encoder_count;
    logic signed [pvff_pkg::TGT_W-1:0]   target_ticks;

    modport source (output valid, output mode, output encoder_count, output target_ticks,
                    input ready);
    modport sink (input valid, input mode, input encoder_count, input target_ticks,
                  output ready);
endinterface

interface pvff_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pvff_pkg::PWM_W-1:0]   pwm_out;
    logic signed [pvff_pkg::COUNT_W-1:0] measured_ticks;
    logic                                saturated;

    modport source (output valid, output pwm_out, output measured_ticks, output saturated,
                    input ready);
    modport sink (input valid, input pwm_out, input measured_ticks, input saturated,
                  output ready);
endinterface

interface pvff_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pvff_pkg::CFG_IDX_W-1:0]      addr;
    logic [pvff_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

### rtl/pvff_div.sv
// Unsigned restoring divider, four quotient bits per cycle, divisor latched at start.
// Depends on pvff_pkg for widths.
module pvff_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pvff_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  logic [pvff_pkg::DIV_W-1:0]         i_divisor,
    output logic [pvff_pkg::DIVIDEND_W-1:0]    o_quotient,
    output logic                               o_busy,
    output logic                               o_done
);
    import pvff_pkg::*;

    logic [DIVIDEND_W-1:0] r_q;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_divisor;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVIDEND_W-1:0] n_q;
    logic [DIV_W-1:0]      n_rem;
    logic [DIV_W:0]        w_trial;

    // Four shift-compare-subtract steps per cycle
    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        w_trial = '0;
        for (int k = 0; k < DIV_DIGIT; k++) begin
            w_trial = {n_rem, n_q[DIVIDEND_W-1]};
            n_q     = {n_q[DIVIDEND_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_divisor}) begin
                w_trial = w_trial - {1'b0, r_divisor};
                n_q[0]  = 1'b1;
            end
            n_rem = w_trial[DIV_W-1:0];
        end
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q       <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_q;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

### rtl/pvff_ctrl.sv
// Sequencer of the speed controller: steps the datapath through one request.
// Depends on pvff_pkg and the assertion macro header.
`include "pid_velocity_feedforward_assert.svh"
module pvff_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_mode,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pvff_pkg::t_status i_status,
    output pvff_pkg::t_cmd    o_cmd
);
    import pvff_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RESYNC,
        S_MEAS,
        S_MUL_FF1,
        S_FF_BASE,
        S_MUL_FF2,
        S_FF_GO,
        S_FF_WAIT,
        S_PID_D,
        S_PID_SUB,
        S_PID_I,
        S_PID_GO,
        S_PID_WAIT,
        S_CLAMP,
        S_FIN,
        S_INTEG,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_in_mode ? S_RESYNC : S_MEAS;
                end
            end
            S_RESYNC: begin
                o_cmd.resync = 1'b1;
                n_state = S_DONE;
            end
            S_MEAS: begin
                o_cmd.meas = 1'b1;
                n_state = S_MUL_FF1;
            end
            S_MUL_FF1: begin
                o_cmd.diff    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SLOPE_MAG;
                n_state = S_FF_BASE;
            end
            S_FF_BASE: begin
                o_cmd.sum_op = SUM_FF_BASE;
                n_state = S_MUL_FF2;
            end
            S_MUL_FF2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SUM_PCT;
                n_state = S_FF_GO;
            end
            S_FF_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DIV_SRC_FF;
                n_state = S_FF_WAIT;
            end
            S_FF_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.ff_load = 1'b1;
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MUL_KP_ERR;
                    n_state = S_PID_D;
                end
            end
            S_PID_D: begin
                o_cmd.sum_op  = SUM_LOAD_PROD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KD_DMEAS;
                n_state = S_PID_SUB;
            end
            S_PID_SUB: begin
                o_cmd.sum_op  = SUM_SUB_PROD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KI_ERR;
                n_state = S_PID_I;
            end
            S_PID_I: begin
                o_cmd.sum_op = SUM_ADD_INTEG;
                n_state = S_PID_GO;
            end
            S_PID_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DIV_SRC_PID;
                n_state = S_PID_WAIT;
            end
            S_PID_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.acc_load = 1'b1;
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand over once the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `PVFF_ASSERT_SAME(a_idle_div_quiet, i_clk, i_rst_n, o_in_ready, !i_status.div_busy, "request taken while divider busy")
    `PVFF_ASSERT_SAME(a_done_in_wait, i_clk, i_rst_n, i_status.div_done, (r_state == S_FF_WAIT) || (r_state == S_PID_WAIT), "divider finished outside a wait state")
    `PVFF_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.out_load, r_out_valid, "loaded result not flagged valid")

endmodule

### rtl/pvff_dp.sv
// Datapath of the speed controller: registers, shared multiplier, accumulator, divider.
// Depends on pvff_pkg, pvff_div and the assertion macro header.
`include "pid_velocity_feedforward_assert.svh"
module pvff_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pvff_pkg::t_cmd                      i_cmd,
    output pvff_pkg::t_status                   o_status,
    input  logic [pvff_pkg::COUNT_W-1:0]        i_encoder_count,
    input  logic signed [pvff_pkg::TGT_W-1:0]   i_target_ticks,
    input  logic                                i_cfg_we,
    input  logic [pvff_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [pvff_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic signed [pvff_pkg::PWM_W-1:0]   o_pwm_out,
    output logic signed [pvff_pkg::COUNT_W-1:0] o_measured_ticks,
    output logic                                o_saturated
);
    import pvff_pkg::*;

    localparam logic signed [DRIVE_W-1:0] MAX_S      = DRIVE_W'(MAX_DRIVE);
    localparam logic signed [ACC_W-1:0]   MAX_A      = ACC_W'(MAX_DRIVE);
    localparam logic signed [ACC_W-1:0]   INTEG_MAX  = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0]   INTEG_MIN  = ~INTEG_MAX;
    localparam logic [SD_W-1:0]           SD_C       = SD_W'(SLOPE_DENOM);

    // Configuration registers
    logic [GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic [FFC_W-1:0]  r_db_fwd, r_slope_fwd, r_db_rev, r_slope_rev;
    logic [PCT_W-1:0]  r_pct;

    // Persistent controller state
    logic [COUNT_W-1:0]        r_prev_count;
    logic signed [COUNT_W-1:0] r_prev_speed;
    logic signed [COUNT_W-1:0] r_pi;
    logic signed [COUNT_W-1:0] r_integ;

    // Per-request working registers
    logic [COUNT_W-1:0]        r_count;
    logic signed [TGT_W-1:0]   r_tgt;
    logic signed [COUNT_W-1:0] r_meas;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_dmeas;
    logic [TGT_W-1:0]          r_mag;
    logic [FFC_W-1:0]          r_db;
    logic [FFC_W-1:0]          r_slope;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [FF_W-1:0]    r_ff;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_hi;
    logic signed [ACC_W-1:0]   r_lo;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_sat;

    // Result register
    logic signed [PWM_W-1:0]   r_out_pwm;
    logic signed [COUNT_W-1:0] r_out_meas;
    logic                      r_out_sat;

    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic [MUL_B_W-1:0]         w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic [DB_BASE_W-1:0]       w_db_base;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    w_sum_mag;
    logic [DIVIDEND_W-1:0]      w_dividend;
    logic [DIV_W-1:0]           w_divisor;
    logic [DIVIDEND_W-1:0]      w_quot;
    logic signed [ACC_W-1:0]    w_q_mag;
    logic signed [ACC_W-1:0]    w_q_signed;
    logic signed [DRIVE_W-1:0]  w_drive;
    logic signed [ACC_W-1:0]    w_integ_sum;
    logic                       w_div_busy;
    logic                       w_div_done;
    logic                       w_tgt_pos;

    assign w_tgt_pos = !r_tgt[TGT_W-1] && (r_tgt != '0);

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SLOPE_MAG: begin
                w_mul_a = MUL_A_W'(r_mag);
                w_mul_b = r_slope;
            end
            MUL_SUM_PCT: begin
                w_mul_a = MUL_A_W'(r_sum);
                w_mul_b = MUL_B_W'(r_pct);
            end
            MUL_KP_ERR: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'(r_kp);
            end
            MUL_KD_DMEAS: begin
                w_mul_a = MUL_A_W'(r_dmeas);
                w_mul_b = MUL_B_W'(r_kd);
            end
            MUL_KI_ERR: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'(r_ki);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = w_mul_a * $signed({1'b0, w_mul_b});
    assign w_db_base = DB_BASE_W'(r_db) * DB_BASE_W'(SD_C);

    // Accumulator next value
    always_comb begin
        case (i_cmd.sum_op)
            SUM_HOLD:      n_sum = r_sum;
            SUM_FF_BASE:   n_sum = SUM_W'(r_prod) + $signed(SUM_W'(w_db_base));
            SUM_LOAD_PROD: n_sum = SUM_W'(r_prod);
            SUM_SUB_PROD:  n_sum = r_sum - SUM_W'(r_prod);
            SUM_ADD_INTEG: n_sum = r_sum + SUM_W'(r_integ);
            default:       n_sum = r_sum;
        endcase
    end

    // Divider operand select: magnitudes only, sign applied afterwards
    assign w_sum_mag  = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign w_dividend = (i_cmd.div_src == DIV_SRC_FF) ? DIVIDEND_W'(r_prod)
                                                      : DIVIDEND_W'(w_sum_mag);
    assign w_divisor  = (i_cmd.div_src == DIV_SRC_FF) ? DIV_W'(FF_DIVISOR)
                                                      : DIV_W'(OUTPUT_DIVISOR);

    pvff_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quot),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done)
    );

    assign o_status.div_busy = w_div_busy;
    assign o_status.div_done = w_div_done;

    // Truncating division: apply the dividend sign to the quotient magnitude
    assign w_q_mag     = $signed(ACC_W'(w_quot));
    assign w_q_signed  = r_sum[SUM_W-1] ? -w_q_mag : w_q_mag;
    assign w_drive     = DRIVE_W'(r_ff) + DRIVE_W'(r_acc);
    assign w_integ_sum = ACC_W'(r_integ) + ACC_W'(r_prod);

    // Configuration and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= PROP_GAIN_RST;
            r_ki         <= INTEG_GAIN_RST;
            r_kd         <= DERIV_GAIN_RST;
            r_db_fwd     <= DEADBAND_FWD_RST;
            r_slope_fwd  <= SLOPE_FWD_RST;
            r_db_rev     <= DEADBAND_REV_RST;
            r_slope_rev  <= SLOPE_REV_RST;
            r_pct        <= FF_SCALE_RST;
            r_prev_count <= '0;
            r_prev_speed <= '0;
            r_pi         <= '0;
            r_integ      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_PROP_GAIN:    r_kp        <= i_cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN:   r_ki        <= i_cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN:   r_kd        <= i_cfg_data[GAIN_W-1:0];
                    CFG_DEADBAND_FWD: r_db_fwd    <= i_cfg_data[FFC_W-1:0];
                    CFG_SLOPE_FWD:    r_slope_fwd <= i_cfg_data[FFC_W-1:0];
                    CFG_DEADBAND_REV: r_db_rev    <= i_cfg_data[FFC_W-1:0];
                    CFG_SLOPE_REV:    r_slope_rev <= i_cfg_data[FFC_W-1:0];
                    CFG_FF_SCALE_PCT: r_pct       <= i_cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end
            // Reset mode: resync the count, clear the loop state
            if (i_cmd.resync) begin
                r_prev_count <= r_count;
                r_prev_speed <= '0;
                r_pi         <= '0;
                r_integ      <= '0;
            end
            if (i_cmd.fin) begin
                r_pi         <= $signed(r_acc[COUNT_W-1:0]);
                r_prev_count <= r_count;
                r_prev_speed <= r_meas;
            end
            // Integral grows only while the drive is off the limit
            if (i_cmd.integ && !r_sat) begin
                if (w_integ_sum > INTEG_MAX) begin
                    r_integ <= INTEG_MAX[COUNT_W-1:0];
                end else if (w_integ_sum < INTEG_MIN) begin
                    r_integ <= INTEG_MIN[COUNT_W-1:0];
                end else begin
                    r_integ <= w_integ_sum[COUNT_W-1:0];
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_count <= i_encoder_count;
            r_tgt   <= i_target_ticks;
        end
        if (i_cmd.resync) begin
            r_meas  <= '0;
            r_drive <= '0;
            r_sat   <= 1'b0;
        end
        if (i_cmd.meas) begin
            r_meas  <= $signed(r_count - r_prev_count);
            r_mag   <= r_tgt[TGT_W-1] ? TGT_W'(-r_tgt) : TGT_W'(r_tgt);
            r_db    <= w_tgt_pos ? r_db_fwd : r_db_rev;
            r_slope <= w_tgt_pos ? r_slope_fwd : r_slope_rev;
        end
        if (i_cmd.diff) begin
            r_err   <= ERR_W'(r_tgt) - ERR_W'(r_meas);
            r_dmeas <= ERR_W'(r_meas) - ERR_W'(r_prev_speed);
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        r_sum <= n_sum;
        // Feedforward is zero for a zero target, signed like the target otherwise
        if (i_cmd.ff_load) begin
            if (r_tgt == '0) begin
                r_ff <= '0;
            end else if (r_tgt[TGT_W-1]) begin
                r_ff <= -$signed(FF_W'(w_quot));
            end else begin
                r_ff <= $signed(FF_W'(w_quot));
            end
        end
        if (i_cmd.acc_load) begin
            r_acc <= w_q_signed + ACC_W'(r_pi);
            r_hi  <= MAX_A - ACC_W'(r_ff);
            r_lo  <= -MAX_A - ACC_W'(r_ff);
        end
        // Clamp the accumulator to the headroom left after the feedforward
        if (i_cmd.clamp) begin
            if (r_acc > r_hi) begin
                r_acc <= r_hi;
            end else if (r_acc < r_lo) begin
                r_acc <= r_lo;
            end
        end
        if (i_cmd.fin) begin
            if (w_drive >= MAX_S) begin
                r_drive <= MAX_S;
                r_sat   <= 1'b1;
            end else if (w_drive <= -MAX_S) begin
                r_drive <= -MAX_S;
                r_sat   <= 1'b1;
            end else begin
                r_drive <= w_drive;
                r_sat   <= 1'b0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_pwm  <= r_drive[PWM_W-1:0];
            r_out_meas <= r_meas;
            r_out_sat  <= r_sat;
        end
    end

    assign o_pwm_out        = r_out_pwm;
    assign o_measured_ticks = r_out_meas;
    assign o_saturated      = r_out_sat;

    `PVFF_ASSERT_NEXT(a_drive_in_range, i_clk, i_rst_n, i_cmd.fin, (r_drive <= MAX_S) && (r_drive >= -MAX_S), "drive outside the limit")
    `PVFF_ASSERT_NEXT(a_sat_at_limit, i_clk, i_rst_n, i_cmd.fin, r_sat == ((r_drive == MAX_S) || (r_drive == -MAX_S)), "saturation flag disagrees with drive")

endmodule

### rtl/pid_velocity_feedforward.sv
// Velocity-form PID speed controller with direction-dependent feedforward.
// The feedforward and PID quotients of a control request each pass through
// the one shared divider, which produces four quotient bits per cycle, and
// the remaining steps run one multiply or add per cycle on a single shared
// multiplier. A finished result sits in an output register, so the next
// request is taken while it waits. Register writes are taken at any time
// and must only be issued idle.
// Depends on pvff_pkg, pvff_if, pvff_ctrl and pvff_dp.
module pid_velocity_feedforward (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pvff_in_if.sink    i_in,
    pvff_out_if.source o_out,
    pvff_cfg_if.sink   i_cfg
);
    import pvff_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    logic    w_out_valid;

    // Register writes are always taken; the write channel never stalls
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    pvff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pvff_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_encoder_count  (i_in.encoder_count),
        .i_target_ticks   (i_in.target_ticks),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_addr       (i_cfg.addr),
        .i_cfg_data       (i_cfg.data),
        .o_pwm_out        (o_out.pwm_out),
        .o_measured_ticks (o_out.measured_ticks),
        .o_saturated      (o_out.saturated)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pid_velocity_feedforward: a drive predictor with its own
// copy of the registers and loop state checks every result in request order.
// Depends on pvff_pkg, pvff_if and the controller RTL.
module tb;
    import pvff_pkg::*;

    localparam int      SETTLE_CYCLES = 8;
    localparam int      END_CYCLES    = 40;
    localparam int      LONG_HOLD     = 300;
    localparam int      N_PHASES      = 20;
    localparam int      PHASE_ITEMS   = 85;
    localparam int      NOISE_PCT     = 15;
    localparam int      MAX_PRINTED   = 40;
    localparam longint  TIMEOUT_NS    = 64'd10_000_000;
    localparam longint  INT32_HI      = 64'sd2147483647;
    localparam longint  INT32_LO      = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;
    localparam logic [15:0] STALL_MASK = 16'b1101_1110_0111_1011;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN
    } t_sink_style;

    typedef struct packed {
        logic signed [PWM_W-1:0]   pwm;
        logic signed [COUNT_W-1:0] meas;
        logic                      sat;
    } drive_rec_t;

    // Predict drive values from accepted requests and check the results against them
    class drive_model;
        logic [GAIN_W-1:0]  kp, ki, kd;
        logic [FFC_W-1:0]   db_fwd, sl_fwd, db_rev, sl_rev;
        logic [PCT_W-1:0]   pct;
        logic [COUNT_W-1:0] prev_count;
        int                 prev_speed, pi_acc, integ_term;
        drive_rec_t         pending_drives[$];
        int n_mismatch, n_requests, n_resyncs, n_results, n_sat, n_writes;

        function new();
            kp         = PROP_GAIN_RST;
            ki         = INTEG_GAIN_RST;
            kd         = DERIV_GAIN_RST;
            db_fwd     = DEADBAND_FWD_RST;
            sl_fwd     = SLOPE_FWD_RST;
            db_rev     = DEADBAND_REV_RST;
            sl_rev     = SLOPE_REV_RST;
            pct        = FF_SCALE_RST;
            prev_count = '0;
            prev_speed = 0;
            pi_acc     = 0;
            integ_term = 0;
        endfunction

        task report_mismatch(string msg);
            if (n_mismatch < MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
            n_mismatch++;
        endtask

        // Update one register; indexes past the list are dropped
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            n_writes++;
            case (idx)
                CFG_PROP_GAIN:    kp = data[7:0];
                CFG_INTEG_GAIN:   ki = data[7:0];
                CFG_DERIV_GAIN:   kd = data[7:0];
                CFG_DEADBAND_FWD: db_fwd = data;
                CFG_SLOPE_FWD:    sl_fwd = data;
                CFG_DEADBAND_REV: db_rev = data;
                CFG_SLOPE_REV:    sl_rev = data;
                CFG_FF_SCALE_PCT: pct = data[7:0];
                default: ;
            endcase
        endfunction

        // Advance the loop state by one request and queue the drive it yields
        function void take_request(logic mode, logic [COUNT_W-1:0] count,
                                   logic signed [TGT_W-1:0] tgt_in);
            drive_rec_t         r;
            logic [COUNT_W-1:0] diff;
            longint t, meas, err, ff, acc, hi, lo, drive, integ, mag, db, sl;
            logic   sat;
            n_requests++;
            if (mode) begin
                // Resync the count and clear the accumulators
                n_resyncs++;
                prev_count = count;
                prev_speed = 0;
                pi_acc     = 0;
                integ_term = 0;
                r = '0;
            end else begin
                diff = count - prev_count;
                meas = longint'($signed(diff));
                t    = longint'(tgt_in);
                err  = t - meas;
                ff   = 0;
                if (t != 0) begin
                    mag = (t > 0) ? t : -t;
                    db  = (t > 0) ? longint'(db_fwd) : longint'(db_rev);
                    sl  = (t > 0) ? longint'(sl_fwd) : longint'(sl_rev);
                    ff  = ((db * SLOPE_DENOM + sl * mag) * longint'(pct)) / FF_DIVISOR;
                    if (t < 0) begin
                        ff = -ff;
                    end
                end
                acc = (longint'(kp) * err - longint'(kd) * (meas - longint'(prev_speed))
                       + longint'(integ_term)) / OUTPUT_DIVISOR;
                acc = acc + longint'(pi_acc);
                // Clamp the accumulator to the headroom left after feedforward
                hi = MAX_DRIVE - ff;
                lo = -MAX_DRIVE - ff;
                if (acc > hi) begin
                    acc = hi;
                end else if (acc < lo) begin
                    acc = lo;
                end
                pi_acc = int'(acc);
                drive  = ff + acc;
                sat    = 1'b1;
                if (drive >= MAX_DRIVE) begin
                    drive = MAX_DRIVE;
                end else if (drive <= -MAX_DRIVE) begin
                    drive = -MAX_DRIVE;
                end else begin
                    // Grow the integral only while unsaturated, holding at 32-bit limits
                    sat   = 1'b0;
                    integ = longint'(integ_term) + longint'(ki) * err;
                    if (integ > INT32_HI) begin
                        integ = INT32_HI;
                    end else if (integ < INT32_LO) begin
                        integ = INT32_LO;
                    end
                    integ_term = int'(integ);
                end
                prev_count = count;
                prev_speed = int'(meas);
                r.pwm  = drive[PWM_W-1:0];
                r.meas = meas[COUNT_W-1:0];
                r.sat  = sat;
            end
            pending_drives.push_back(r);
        endfunction

        task check_drive(logic signed [PWM_W-1:0] pwm, logic signed [COUNT_W-1:0] meas,
                         logic sat);
            drive_rec_t r;
            n_results++;
            if (sat === 1'b1) begin
                n_sat++;
            end
            if (pending_drives.size() == 0) begin
                report_mismatch($sformatf("result with no request pending, pwm %0d", pwm));
            end else begin
                r = pending_drives.pop_front();
                if (pwm !== r.pwm) begin
                    report_mismatch($sformatf("pwm_out %0d, predicted %0d", pwm, r.pwm));
                end
                if (meas !== r.meas) begin
                    report_mismatch($sformatf("measured_ticks %0d, predicted %0d",
                                              meas, r.meas));
                end
                if (sat !== r.sat) begin
                    report_mismatch($sformatf("saturated %0b, predicted %0b", sat, r.sat));
                end
            end
        endtask

        task close_out();
            if (pending_drives.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived", pending_drives.size()));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pvff_in_if  req_if();
    pvff_out_if drv_if();
    pvff_cfg_if reg_if();

    pid_velocity_feedforward i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (drv_if),
        .i_cfg   (reg_if)
    );

    drive_model  loop_model;
    t_sink_style sink_style = SINK_OPEN;
    bit          hold_req   = 1'b0;
    bit          src_bursty = 1'b0;
    bit          req_live   = 1'b0;
    int          burst_left = 0;
    int          n_holds    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watch all three channels at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            loop_model.take_request(req_if.mode, req_if.encoder_count, req_if.target_ticks);
        end
        if (i_rst_n && drv_if.valid && drv_if.ready) begin
            loop_model.check_drive(drv_if.pwm_out, drv_if.measured_ticks, drv_if.saturated);
        end
        if (i_rst_n && reg_if.valid && reg_if.ready) begin
            loop_model.set_reg(reg_if.addr, reg_if.data);
        end
    end

    // Result side: stall per the current style, or hold off for a long stretch on request
    initial begin : result_sink
        int pos;
        int run_left;
        bit rdy;
        bit rdy_state;
        pos       = 0;
        run_left  = 0;
        rdy_state = 1'b1;
        drv_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                drv_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                n_holds++;
            end else begin
                case (sink_style)
                    SINK_OPEN: rdy = 1'b1;
                    SINK_RANDOM: begin
                        if (run_left == 0) begin
                            rdy_state = ($urandom_range(0, 2) != 0);
                            run_left  = $urandom_range(1, 12);
                        end
                        run_left--;
                        rdy = rdy_state;
                    end
                    default: begin
                        rdy = STALL_MASK[pos];
                        pos = (pos + 1) % 16;
                    end
                endcase
                drv_if.ready <= rdy;
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("** pid_velocity_feedforward: FAILED **");
        $finish;
    end

    // Offer one request and hold it until taken; open a gap when a burst runs out
    task automatic send_req(logic mode, logic [COUNT_W-1:0] count, logic [TGT_W-1:0] tgt);
        int gap;
        req_if.valid         <= 1'b1;
        req_if.mode          <= mode;
        req_if.encoder_count <= count;
        req_if.target_ticks  <= tgt;
        req_live = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        if (src_bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 48);
                req_if.valid <= 1'b0;
                req_live = 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Write one register; keep valid up across a group of writes
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data,
                             bit last);
        reg_if.valid <= 1'b1;
        reg_if.addr  <= idx;
        reg_if.data  <= data;
        do @(posedge i_clk); while (!reg_if.ready);
        if (last) begin
            reg_if.valid <= 1'b0;
        end
    endtask

    task automatic apply_setting(logic [9:0] kp, logic [9:0] ki, logic [9:0] kd,
                                 logic [9:0] dbf, logic [9:0] slf, logic [9:0] dbr,
                                 logic [9:0] slr, logic [9:0] pct);
        write_cfg(CFG_PROP_GAIN, kp, 1'b0);
        write_cfg(CFG_INTEG_GAIN, ki, 1'b0);
        write_cfg(CFG_DERIV_GAIN, kd, 1'b0);
        write_cfg(CFG_DEADBAND_FWD, dbf, 1'b0);
        write_cfg(CFG_SLOPE_FWD, slf, 1'b0);
        write_cfg(CFG_DEADBAND_REV, dbr, 1'b0);
        write_cfg(CFG_SLOPE_REV, slr, 1'b0);
        write_cfg(CFG_FF_SCALE_PCT, pct, 1'b1);
    endtask

    // Drop valid and wait until every predicted result has been checked
    task automatic drain_results();
        if (req_live) begin
            req_if.valid <= 1'b0;
            req_live = 1'b0;
        end
        do @(posedge i_clk); while (loop_model.pending_drives.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_setting();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
        end else if (pick == 1) begin
            apply_setting(255, 255, 255, 1023, 1023, 1023, 1023, 200);
        end else if (pick < 6) begin
            // Gentle gains keep the loop out of saturation most of the time
            apply_setting(10'($urandom_range(0, 40)), 10'($urandom_range(0, 8)),
                          10'($urandom_range(0, 40)), 10'($urandom_range(0, 150)),
                          10'($urandom_range(0, 300)), 10'($urandom_range(0, 150)),
                          10'($urandom_range(0, 300)), 10'($urandom_range(0, 200)));
        end else begin
            apply_setting(10'($urandom()), 10'($urandom()), 10'($urandom()),
                          10'($urandom()), 10'($urandom()), 10'($urandom()),
                          10'($urandom()), 10'($urandom()));
        end
        if ($urandom_range(0, 3) == 0) begin
            write_cfg(4'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)), 10'($urandom()), 1'b1);
        end
    endtask

    function automatic int pick_target();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return int'($urandom_range(0, 120)) - 60;
        end else if (r < 9) begin
            return int'($urandom_range(0, 1200)) - 600;
        end
        return int'($signed(16'($urandom())));
    endfunction

    // Resync, then track a target with a plausible encoder trace, mixed with noise
    task automatic run_phase(int n_items, int noise);
        logic [COUNT_W-1:0] count;
        int  speed, tgt, roll, i;
        bit  mode;
        if ($urandom_range(0, 3) == 0) begin
            count = 32'hFFFF_FF00 + $urandom_range(0, 255);
        end else begin
            count = $urandom();
        end
        send_req(1'b1, count, 16'($urandom()));
        speed = 0;
        tgt   = pick_target();
        for (i = 1; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < noise) begin
                mode  = ($urandom_range(0, 4) == 0);
                count = $urandom();
                send_req(mode, count, 16'($urandom()));
                if (mode) begin
                    speed = 0;
                end
            end else begin
                if (roll > 95) begin
                    tgt = pick_target();
                end
                speed = speed + (tgt - speed) / 3 + int'($urandom_range(0, 4)) - 2;
                count = count + 32'(speed);
                send_req(1'b0, count, 16'(tgt));
            end
        end
    endtask

    initial begin : stimulus
        int ph;
        loop_model = new();
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.mode          <= 1'b0;
        req_if.encoder_count <= '0;
        req_if.target_ticks  <= '0;
        reg_if.valid         <= 1'b0;
        reg_if.addr          <= '0;
        reg_if.data          <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: target extremes, zero target, count wrap, speed extremes
        send_req(1'b1, 32'h0000_0000, 16'sd0);
        send_req(1'b0, 32'h0000_0064, 16'sd100);
        send_req(1'b0, 32'h0000_00C8, 16'sh7FFF);
        send_req(1'b0, 32'h0000_0096, 16'sh8000);
        send_req(1'b0, 32'h0000_0096, 16'sd0);
        send_req(1'b1, 32'hFFFF_FFF0, 16'sd12345);
        send_req(1'b0, 32'h0000_0010, 16'sd30);
        send_req(1'b0, 32'h8000_0010, 16'sd0);
        send_req(1'b0, 32'h0000_000F, 16'sd0);
        send_req(1'b0, 32'hFFFF_FFFF, -16'sd1);
        drain_results();

        // Feedforward lands exactly on the limit, then just inside it
        apply_setting(0, 0, 0, 255, 0, 255, 0, 100);
        send_req(1'b1, 32'h0000_0000, 16'sd0);
        send_req(1'b0, 32'h0000_0000, 16'sd1);
        send_req(1'b0, 32'h0000_0000, -16'sd1);
        drain_results();
        write_cfg(CFG_DEADBAND_FWD, 10'd254, 1'b1);
        send_req(1'b0, 32'h0000_0000, 16'sd1);
        drain_results();

        // Integral term runs into its negative then positive 32-bit limit
        apply_setting(0, 255, 0, 0, 0, 0, 0, 0);
        send_req(1'b1, 32'h0000_0000, 16'sd0);
        send_req(1'b0, 32'h7FFF_FFFF, 16'sd0);
        send_req(1'b0, 32'h7FFF_FFFF, 16'sd0);
        send_req(1'b1, 32'h0000_0000, 16'sd0);
        send_req(1'b0, 32'h8000_0000, 16'sd0);
        drain_results();

        // All fields at maximum, scale above its nominal range
        apply_setting(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        send_req(1'b1, 32'h1234_5678, 16'sd0);
        send_req(1'b0, 32'h1234_5700, 16'sd200);
        send_req(1'b0, 32'h1234_5600, -16'sd300);
        drain_results();

        // Writes past the register list change nothing
        write_cfg(CFG_UNUSED_LO, 10'd0, 1'b0);
        write_cfg(CFG_UNUSED_HI, 10'd0, 1'b1);
        send_req(1'b0, 32'h1234_5680, 16'sd150);
        send_req(1'b0, 32'h1234_5600, -16'sd150);
        drain_results();

        // Random phases, each with its own setting and idling style
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            if (ph == 1) begin
                apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
            end else if (ph == 2) begin
                apply_setting(255, 255, 255, 1023, 1023, 1023, 1023, 200);
            end else begin
                random_setting();
            end
            sink_style = t_sink_style'(ph % 3);
            src_bursty = (ph % 4 != 3);
            burst_left = $urandom_range(1, 24);
            if (ph == 5) begin
                // Back up the block behind a stalled result while requests keep coming
                src_bursty = 1'b0;
                hold_req   = 1'b1;
            end
            if (ph == 8) begin
                run_phase(40, NOISE_PCT);
                drain_results();
                run_phase(PHASE_ITEMS - 40, NOISE_PCT);
            end else begin
                run_phase(PHASE_ITEMS, (ph == 2) ? 50 : NOISE_PCT);
            end
        end

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        loop_model.close_out();
        $display("covered %0d requests (%0d resyncs), %0d results, %0d saturated",
                 loop_model.n_requests, loop_model.n_resyncs, loop_model.n_results,
                 loop_model.n_sat);
        $display("%0d register writes over %0d phases, %0d long result stalls, %0d mismatches",
                 loop_model.n_writes, N_PHASES, n_holds, loop_model.n_mismatch);
        if (loop_model.n_mismatch == 0) begin
            $display("** pid_velocity_feedforward: PASSED **");
        end else begin
            $display("** pid_velocity_feedforward: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/pvff_pkg.sv
rtl/pvff_if.sv
rtl/pvff_div.sv
rtl/pvff_ctrl.sv
rtl/pvff_dp.sv
rtl/pid_velocity_feedforward.sv
tb/tb.sv
